@@ sv/cfbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfbs_pkg
// Shared types, register indexes and the CRC-16 byte update for the
// framed bit serializer.
// ----------------------------------------------------------------------------
package cfbs_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Configuration register indexes
    localparam logic [1:0] REG_PREAMBLE = 2'd0;
    localparam logic [1:0] REG_START    = 2'd1;
    localparam logic [1:0] REG_END      = 2'd2;

    // Reset values of the configuration registers
    localparam logic [7:0] PREAMBLE_RST = 8'h55;
    localparam logic [7:0] START_RST    = 8'h7E;
    localparam logic [7:0] END_RST      = 8'h7E;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] type_flag;
        logic [7:0] message_length;
    } in_item_t;

    typedef struct packed {
        logic line_bit;
        logic run_last;
        logic frame_last;
    } out_item_t;

    // Classified item handed from the front to the back
    typedef struct packed {
        logic [7:0]  data;
        logic [7:0]  flag;
        logic [7:0]  len;
        logic        first;   // send the header before this item
        logic        zero;    // zero-length frame: no payload byte
        logic        last;    // send the trailer after this item
        logic [15:0] crc;     // CRC after this item
    } entry_t;

    typedef struct packed {
        logic [7:0] preamble_byte;
        logic [7:0] start_byte;
        logic [7:0] end_byte;
    } cfg_t;

    // CRC-16/CCITT-FALSE, one byte, poly 0x1021, MSB first
    function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [7:0]  x;
        logic [15:0] x16;
        x   = crc[15:8] ^ b;
        x   = x ^ (x >> 4);
        x16 = {8'h00, x};
        return {crc[7:0], 8'h00} ^ (x16 << 12) ^ (x16 << 5) ^ x16;
    endfunction

endpackage

@@ sv/cfbs_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfbs_front
// Accepts input items, tracks the frame position and the running CRC and
// pushes one classified entry per item into the queue.
// ----------------------------------------------------------------------------
module cfbs_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  cfbs_pkg::in_item_t in_data,
    input  logic              q_full,
    output logic              accept,
    output logic              push,
    output cfbs_pkg::entry_t  push_entry
);
    import cfbs_pkg::*;

    logic        in_frame_reg, in_frame_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic [15:0] crc_reg, crc_next;

    logic [15:0] crc_base;
    logic [15:0] crc_new;
    logic [7:0]  left_now;

    assign accept = in_valid && !q_full;
    assign push   = accept;

    // Classify the item and compute the next frame state
    always_comb
    begin
        crc_base = in_frame_reg ? crc_reg : CRC_INIT;
        left_now = in_frame_reg ? bytes_left_reg : in_data.message_length;
        crc_new  = crc_update(crc_base, in_data.payload_byte);

        push_entry.data  = in_data.payload_byte;
        push_entry.flag  = in_data.type_flag;
        push_entry.len   = in_data.message_length;
        push_entry.first = !in_frame_reg;
        push_entry.zero  = !in_frame_reg && (in_data.message_length == 8'd0);
        push_entry.last  = push_entry.zero || (left_now == 8'd1);
        push_entry.crc   = push_entry.zero ? CRC_INIT : crc_new;

        in_frame_next   = in_frame_reg;
        bytes_left_next = bytes_left_reg;
        crc_next        = crc_reg;
        if (accept)
        begin
            if (push_entry.last)
            begin
                in_frame_next   = 1'b0;
                bytes_left_next = 8'd0;
                crc_next        = CRC_INIT;
            end
            else
            begin
                in_frame_next   = 1'b1;
                bytes_left_next = left_now - 8'd1;
                crc_next        = crc_new;
            end
        end
    end

    // Hold the frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            bytes_left_reg <= 8'd0;
            crc_reg        <= CRC_INIT;
        end
        else
        begin
            in_frame_reg   <= in_frame_next;
            bytes_left_reg <= bytes_left_next;
            crc_reg        <= crc_next;
        end
    end

endmodule

@@ sv/cfbs_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfbs_queue
// Two-entry queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module cfbs_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cfbs_pkg::entry_t push_entry,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output cfbs_pkg::entry_t head
);
    import cfbs_pkg::*;

    entry_t     mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

@@ sv/cfbs_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfbs_back
// Serializes each queued item: header, payload byte and trailer as needed,
// one bit per cycle while out_stall is low, MSB first, into an output register.
// ----------------------------------------------------------------------------
module cfbs_back (
    input  logic                clk,
    input  logic                rst_n,
    input  cfbs_pkg::cfg_t      cfg,
    input  logic                q_not_empty,
    input  cfbs_pkg::entry_t    q_head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output cfbs_pkg::out_item_t out_data
);
    import cfbs_pkg::*;

    // Byte slots of one item's run
    localparam logic [2:0] SLOT_PRE  = 3'd0;
    localparam logic [2:0] SLOT_SOF  = 3'd1;
    localparam logic [2:0] SLOT_FLAG = 3'd2;
    localparam logic [2:0] SLOT_LEN  = 3'd3;
    localparam logic [2:0] SLOT_DATA = 3'd4;
    localparam logic [2:0] SLOT_CRCH = 3'd5;
    localparam logic [2:0] SLOT_CRCL = 3'd6;
    localparam logic [2:0] SLOT_END  = 3'd7;

    entry_t     cur_reg, cur_next;
    logic       busy_reg, busy_next;
    logic [2:0] slot_reg, slot_next;
    logic [2:0] bit_reg, bit_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_reg, out_next;

    logic       out_free;
    logic       step;
    logic       byte_end;
    logic       run_end;
    logic [7:0] cur_byte;
    logic [2:0] slot_after;

    assign out_free  = !out_valid_reg || !out_stall;
    assign step      = busy_reg && out_free;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Pick the byte of the current slot
    always_comb
    begin
        case (slot_reg)
            SLOT_PRE:  cur_byte = cfg.preamble_byte;
            SLOT_SOF:  cur_byte = cfg.start_byte;
            SLOT_FLAG: cur_byte = cur_reg.flag;
            SLOT_LEN:  cur_byte = cur_reg.len;
            SLOT_DATA: cur_byte = cur_reg.data;
            SLOT_CRCH: cur_byte = cur_reg.crc[15:8];
            SLOT_CRCL: cur_byte = cur_reg.crc[7:0];
            default:   cur_byte = cfg.end_byte;
        endcase
    end

    // Sequence slots and bits, refill from the queue when idle or at run end
    always_comb
    begin
        byte_end = (bit_reg == 3'd7);
        run_end  = byte_end &&
                   ((slot_reg == SLOT_END) || (slot_reg == SLOT_DATA && !cur_reg.last));

        case (slot_reg)
            SLOT_LEN: slot_after = cur_reg.zero ? SLOT_CRCH : SLOT_DATA;
            default:  slot_after = slot_reg + 3'd1;
        endcase

        pop = q_not_empty && (!busy_reg || (step && run_end));

        cur_next  = cur_reg;
        busy_next = busy_reg;
        slot_next = slot_reg;
        bit_next  = bit_reg;
        if (step)
        begin
            bit_next = bit_reg + 3'd1;
            if (byte_end)
                slot_next = slot_after;
            if (run_end)
                busy_next = 1'b0;
        end
        if (pop)
        begin
            cur_next  = q_head;
            busy_next = 1'b1;
            slot_next = q_head.first ? SLOT_PRE : SLOT_DATA;
            bit_next  = 3'd0;
        end

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_free)
        begin
            out_valid_next      = step;
            out_next.line_bit   = cur_byte[3'd7 - bit_reg];
            out_next.run_last   = run_end;
            out_next.frame_last = byte_end && (slot_reg == SLOT_END);
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            slot_reg      <= SLOT_PRE;
            bit_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            slot_reg      <= slot_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

endmodule

@@ sv/crc16_frame_bit_serializer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_frame_bit_serializer
// Frames payload bytes with header and CRC-16 trailer and sends them as bits.
//
// Input channel (in_valid / in_stall / in_data): one payload byte per item;
// type_flag and message_length are read on the first item of a frame only.
// Output channel (out_valid / out_stall / out_data): one frame bit per item,
// MSB of each byte first, run_last on the last bit of an input item and
// frame_last on the last bit of the end byte.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready;
// index 0 preamble, 1 start, 2 end byte, index 3 is ignored.
// Throughput: one bit per cycle from the serializer while out_stall is low; a
// mid-frame item gives 8 bits, a frame's first item 40, its last 24 more
// (CRC and end byte); a zero-length frame gives 56.
// A two-entry queue lets the front accept items while the serializer works.
// Reset clears the frame state, the CRC to 0xFFFF and the config registers to
// their defaults. A stalled receiver holds the output bit; the queue then
// fills and in_stall rises.
// ----------------------------------------------------------------------------
module crc16_frame_bit_serializer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  cfbs_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output cfbs_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data
);
    import cfbs_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    logic   q_full;
    logic   q_not_empty;
    logic   accept;
    logic   push;
    logic   pop;
    entry_t push_entry;
    entry_t q_head;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;

    // Decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PREAMBLE: cfg_next.preamble_byte = cfg_data;
                REG_START:    cfg_next.start_byte    = cfg_data;
                REG_END:      cfg_next.end_byte      = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.preamble_byte <= PREAMBLE_RST;
            cfg_reg.start_byte    <= START_RST;
            cfg_reg.end_byte      <= END_RST;
        end
        else
            cfg_reg <= cfg_next;
    end

    cfbs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_data    (in_data),
        .q_full     (q_full),
        .accept     (accept),
        .push       (push),
        .push_entry (push_entry)
    );

    cfbs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push && accept),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    cfbs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule
